// ===== hdl/dvrt_pkg.sv =====
`timescale 1ns / 1ps
package dvrt_pkg;
    localparam int Nodes = 16;
    localparam int NodeW = 4;
    localparam logic [15:0] InfCost = 16'hFFFF;

    // configuration register indexes
    localparam logic [1:0] REG_OWN_ID  = 2'd0;
    localparam logic [1:0] REG_NB_MASK = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    typedef enum logic [2:0] {
        CMD_CONTACT = 3'd0,
        CMD_ADVERT  = 3'd1,
        CMD_COST    = 3'd2,
        CMD_TICK    = 3'd3,
        CMD_LOOKUP  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        FWD_HERE = 2'd0,
        FWD_HOP  = 2'd1,
        FWD_NONE = 2'd2
    } fwd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_SWEEP
    } state_t;

    // one classified command, queued between front and back
    typedef struct packed {
        cmd_t        cmd;
        logic        peer_ok;
        logic        dest_ok;
        logic [3:0]  peer;
        logic [3:0]  dest;
        logic [15:0] metric;
        logic        self_hop;
        logic [31:0] tval;
    } op_t;

    // one result item
    typedef struct packed {
        logic        kind;
        logic [3:0]  dest_node;
        logic [15:0] route_cost;
        logic [3:0]  hop_node;
        logic        hop_valid;
        logic [1:0]  forward_status;
        logic        last;
    } res_t;
endpackage

// ===== hdl/dvrt_front.sv =====
`timescale 1ns / 1ps
module dvrt_front import dvrt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [3:0]  own_id,
    input  logic [15:0] neighbor_mask,
    output logic        q_valid,
    input  logic        q_pop,
    output op_t         q_op
);
    // two-entry queue
    op_t        mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    op_t        op;
    logic       push;

    // classify the incoming transfer
    always_comb begin
        op.cmd      = cmd_t'(s_tdata[2:0]);
        op.peer     = s_tdata[6:3];
        op.dest     = s_tdata[10:7];
        op.metric   = s_tdata[26:11];
        op.peer_ok  = (op.peer != own_id) && neighbor_mask[op.peer];
        op.dest_ok  = (op.dest != own_id);
        op.self_hop = s_tdata[31] && (s_tdata[30:27] == own_id);
        op.tval     = s_tdata[63:32];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_op     = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= op;
    end

    // advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ===== hdl/dvrt_back.sv =====
`timescale 1ns / 1ps
module dvrt_back import dvrt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_pop,
    input  op_t         q_op,
    input  logic [3:0]  own_id,
    input  logic [15:0] neighbor_mask,
    input  logic [7:0]  down_timeout,
    output logic        m_tvalid,
    input  logic        m_tready,
    output res_t        m_res
);
    logic [15:0] dist_reg [Nodes];
    logic [3:0]  hop_reg  [Nodes];
    logic [Nodes-1:0] hok_reg, down_reg;
    logic [15:0] cost_reg [Nodes];
    logic [31:0] heard_reg [Nodes];
    logic [31:0] now_reg;

    state_t      state_reg, state_next;
    logic [3:0]  idx_reg, idx_next;
    logic        ov_reg;
    res_t        res_reg;
    logic        out_free, emit;
    res_t        res_next;
    logic [16:0] sum;
    logic [15:0] cand;
    logic [3:0]  p, d, lastidx;
    logic [32:0] limit;

    assign out_free = !ov_reg || m_tready;
    assign m_tvalid = ov_reg;
    assign m_res    = res_reg;
    assign p        = q_op.peer;
    assign d        = q_op.dest;
    assign sum      = {1'b0, cost_reg[p]} + {1'b0, q_op.metric};
    assign cand     = sum[16] ? InfCost : sum[15:0];
    assign lastidx  = (own_id == 4'd15) ? 4'd14 : 4'd15;
    assign limit    = {1'b0, heard_reg[idx_reg]} + {25'd0, down_timeout};

    // sequence commands and table walk
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        res_next   = '0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_op.cmd == CMD_TICK) begin
                        state_next = ST_EMIT;
                        idx_next   = '0;
                    end else if (q_op.cmd == CMD_LOOKUP) begin
                        if (out_free) begin
                            q_pop    = 1'b1;
                            emit     = 1'b1;
                            res_next.kind      = 1'b1;
                            res_next.dest_node = d;
                            res_next.last      = 1'b1;
                            if (!q_op.dest_ok) begin
                                res_next.forward_status = FWD_HERE;
                            end else if (hok_reg[d]) begin
                                res_next.route_cost     = dist_reg[d];
                                res_next.hop_node       = hop_reg[d];
                                res_next.hop_valid      = 1'b1;
                                res_next.forward_status = FWD_HOP;
                            end else begin
                                res_next.route_cost     = dist_reg[d];
                                res_next.forward_status = FWD_NONE;
                            end
                        end
                    end else begin
                        q_pop = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (idx_reg == own_id) begin
                    idx_next = idx_reg + 4'd1;
                end else if (out_free) begin
                    emit = 1'b1;
                    res_next.dest_node  = idx_reg;
                    res_next.route_cost = dist_reg[idx_reg];
                    res_next.hop_node   = hok_reg[idx_reg] ? hop_reg[idx_reg] : 4'd0;
                    res_next.hop_valid  = hok_reg[idx_reg];
                    res_next.last       = (idx_reg == lastidx);
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg == lastidx) begin
                        state_next = ST_SWEEP;
                        idx_next   = '0;
                    end
                end
            end
            ST_SWEEP: begin
                idx_next = idx_reg + 4'd1;
                if (idx_reg == 4'd15) begin
                    state_next = ST_IDLE;
                    q_pop      = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
            hok_reg   <= '0;
            down_reg  <= '0;
            now_reg   <= '0;
            for (int i = 0; i < Nodes; i++) begin
                dist_reg[i]  <= InfCost;
                cost_reg[i]  <= InfCost;
                heard_reg[i] <= '0;
                hop_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            // hold result until taken
            if (emit) begin
                ov_reg  <= 1'b1;
                res_reg <= res_next;
            end else if (m_tready) begin
                ov_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE && q_valid) begin
                case (q_op.cmd)
                    CMD_CONTACT: if (q_op.peer_ok) begin
                        heard_reg[p] <= now_reg;
                        if (down_reg[p]) begin
                            down_reg[p] <= 1'b0;
                            if ((hok_reg[p] && hop_reg[p] == p) || cost_reg[p] < dist_reg[p]) begin
                                dist_reg[p] <= cost_reg[p];
                                hop_reg[p]  <= p;
                                hok_reg[p]  <= 1'b1;
                            end
                        end
                    end
                    CMD_ADVERT: if (q_op.peer_ok && q_op.dest_ok) begin
                        if ((hok_reg[d] && hop_reg[d] == p)
                            || (cand < dist_reg[d] && !q_op.self_hop)) begin
                            dist_reg[d] <= cand;
                            hop_reg[d]  <= p;
                            hok_reg[d]  <= 1'b1;
                        end
                    end
                    CMD_COST: if (q_op.peer_ok) begin
                        cost_reg[p] <= q_op.metric;
                        if (!down_reg[p] && ((hok_reg[p] && hop_reg[p] == p)
                            || q_op.metric < dist_reg[p])) begin
                            dist_reg[p] <= q_op.metric;
                            hop_reg[p]  <= p;
                            hok_reg[p]  <= 1'b1;
                        end
                    end
                    CMD_TICK: begin
                        now_reg <= q_op.tval;
                    end
                    default: ;
                endcase
            end
            // sweep: test one link per cycle, drop routes through it
            if (state_reg == ST_SWEEP) begin
                if (idx_reg != own_id && neighbor_mask[idx_reg] && !down_reg[idx_reg]
                    && ({1'b0, now_reg} > limit)) begin
                    down_reg[idx_reg] <= 1'b1;
                    for (int j = 0; j < Nodes; j++) begin
                        if (hok_reg[j] && hop_reg[j] == idx_reg) begin
                            dist_reg[j] <= InfCost;
                            hop_reg[j]  <= '0;
                            hok_reg[j]  <= 1'b0;
                        end
                    end
                end
            end
        end
    end
endmodule

// ===== hdl/distance_vector_route_table.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Payload
// s_      | in  | command, peer, destination, distance, adv_next_hop, adv_hop_valid, time_value
// m_      | out | dest_node, route_cost, hop_node, hop_valid, forward_status; kind; last
// cfg_    | in  | own_id(0), neighbor_mask(1), down_timeout(2)
// Contact, advert and cost change are applied in the back end; a lookup waits until m_ is free.
// A clock tick emits the table entries (own_id's slot is skipped), then sweeps link timeouts.
// Reset is synchronous (aresetn low); the table returns to no routes at once.
// A two-entry queue lets s_ accept while the back end waits on m_tready.
module distance_vector_route_table import dvrt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0] peer[6:3] destination[10:7] distance[26:11]
    // adv_next_hop[30:27] adv_hop_valid[31] time_value[63:32]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // dest_node[3:0] route_cost[19:4] hop_node[23:20] hop_valid[24] forward_status[26:25]
    output logic [31:0] m_tdata,
    // kind
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [3:0]  own_reg;
    logic [15:0] mask_reg;
    logic [7:0]  tmo_reg;
    logic        q_valid, q_pop;
    op_t         q_op;
    res_t        res;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_reg  <= '0;
            mask_reg <= '0;
            tmo_reg  <= 8'd3;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_OWN_ID:  own_reg  <= cfg_data[3:0];
                REG_NB_MASK: mask_reg <= cfg_data;
                REG_TIMEOUT: tmo_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    dvrt_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .own_id(own_reg), .neighbor_mask(mask_reg),
        .q_valid, .q_pop, .q_op
    );

    dvrt_back u_back (
        .aclk, .aresetn, .q_valid, .q_pop, .q_op,
        .own_id(own_reg), .neighbor_mask(mask_reg), .down_timeout(tmo_reg),
        .m_tvalid, .m_tready, .m_res(res)
    );

    assign m_tdata = {5'd0, res.forward_status, res.hop_valid, res.hop_node,
                      res.route_cost, res.dest_node};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
endmodule

// ===== hdl/dvrt_checker.sv =====
`timescale 1ns / 1ps
module dvrt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("m hold");
    // lookups are single results
    a_lk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast) else $error("lookup last");
    // entries carry status zero
    a_ent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[26:25] == 2'd0) else $error("entry status");
    // no hop without valid
    a_hop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[24] |-> m_tdata[23:20] == 4'd0) else $error("hop");
endmodule

bind distance_vector_route_table dvrt_checker u_chk (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);
